FILE: rtl/core/rba_pkg.sv
`timescale 1ns / 1ps

package rba_pkg;

	localparam int IN_TIME_W     = 32;
	localparam int OUT_TIME_W    = 48;
	localparam int ROOM_W        = 4;
	localparam int CNT_W         = 32;
	localparam int CFG_W         = 5;

	localparam int MAX_ROOMS_DEF = 16;
	localparam int TIME_BITS_DEF = 48;

	localparam logic [CFG_W-1:0] ROOM_COUNT_RST = CFG_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX        = '1;

	// Write controls from the sequencer to the room store.
	typedef struct packed {
		logic wr_en;
		logic clear;
	} store_ctl_t;

endpackage

FILE: rtl/core/rba_room_store.sv
`timescale 1ns / 1ps

module rba_room_store #(
	parameter int MAX_ROOMS = rba_pkg::MAX_ROOMS_DEF,
	parameter int TIME_BITS = rba_pkg::TIME_BITS_DEF,
	parameter int IW        = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rba_pkg::store_ctl_t          ctl,
	input  logic [IW-1:0]                wr_addr,
	input  logic [TIME_BITS-1:0]         wr_free,
	input  logic [rba_pkg::CNT_W-1:0]    wr_cnt,
	input  logic [IW-1:0]                rd_addr,
	output logic [TIME_BITS-1:0]         rd_free,
	output logic [rba_pkg::CNT_W-1:0]    rd_cnt
);

	logic [TIME_BITS-1:0]      free_mem [MAX_ROOMS];
	logic [rba_pkg::CNT_W-1:0] cnt_mem  [MAX_ROOMS];
	logic [MAX_ROOMS-1:0]      valid_q;
	logic [TIME_BITS-1:0]      rd_free_q;
	logic [rba_pkg::CNT_W-1:0] rd_cnt_q;
	logic                      rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			free_mem[wr_addr] <= wr_free;
			cnt_mem[wr_addr]  <= wr_cnt;
		end
		rd_free_q <= free_mem[rd_addr];
		rd_cnt_q  <= cnt_mem[rd_addr];
	end

	// An entry that has not been written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_free = rd_vld_q ? rd_free_q : '0;
	assign rd_cnt  = rd_vld_q ? rd_cnt_q  : '0;

endmodule

FILE: rtl/core/rba_cmp_unit.sv
`timescale 1ns / 1ps

module rba_cmp_unit #(
	parameter int TIME_BITS = rba_pkg::TIME_BITS_DEF
) (
	input  logic [TIME_BITS-1:0]          room_free,
	input  logic [TIME_BITS-1:0]          early_free,
	input  logic [rba_pkg::IN_TIME_W-1:0] start,
	input  logic [rba_pkg::IN_TIME_W-1:0] dur,
	input  logic                          use_start,
	output logic                          free_hit,
	output logic                          earlier,
	output logic [TIME_BITS-1:0]          booked
);

	logic [TIME_BITS-1:0] start_ext;
	logic [TIME_BITS-1:0] base;
	logic [TIME_BITS:0]   sum;

	assign start_ext = TIME_BITS'(start);
	assign free_hit  = room_free <= start_ext;
	assign earlier   = room_free < early_free;

	// The end time saturates when the sum carries out of the time width.
	assign base   = use_start ? start_ext : early_free;
	assign sum    = {1'b0, base} + (TIME_BITS + 1)'(dur);
	assign booked = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

endmodule

FILE: rtl/core/room_booking_allocator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  start_time, stop_time, last_meeting
// out       output     out_valid/ out_stall room, booked_until, most_booked, batch_done
// cfg       input      cfg_wr_en            cfg_wr_data (room count)
//
// A request passes through the scan, fetch and update steps from acceptance to a loaded result;
// the scan reads one room a cycle from the store's single read port. A new request is taken
// once the sequencer is back at idle, so only one request is in work at a time.
// Reset clears the store through per-room valid bits; a last request clears them at once.
// A stalled result holds in the output register, and the next request may enter meanwhile.

module room_booking_allocator_unit #(
	parameter int MAX_ROOMS = rba_pkg::MAX_ROOMS_DEF,
	parameter int TIME_BITS = rba_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rba_pkg::CFG_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rba_pkg::IN_TIME_W-1:0]  start_time,
	input  logic [rba_pkg::IN_TIME_W-1:0]  stop_time,
	input  logic                           last_meeting,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rba_pkg::ROOM_W-1:0]     room,
	output logic [rba_pkg::OUT_TIME_W-1:0] booked_until,
	output logic [rba_pkg::ROOM_W-1:0]     most_booked,
	output logic                           batch_done
);

	localparam int IW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int CW = $clog2(MAX_ROOMS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FETCH  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]                      state_q;
	logic [rba_pkg::CFG_W-1:0]       room_count_q;
	logic [CW-1:0]                   n_q;
	logic [CW-1:0]                   n_w;
	logic [CW-1:0]                   idx_q;
	logic [rba_pkg::IN_TIME_W-1:0]   start_q;
	logic [rba_pkg::IN_TIME_W-1:0]   dur_q;
	logic                            last_q;
	logic                            found_q;
	logic [IW-1:0]                   pick_q;
	logic [IW-1:0]                   early_q;
	logic [TIME_BITS-1:0]            early_free_q;
	logic [TIME_BITS-1:0]            booked_q;
	logic [IW-1:0]                   best_room_q;
	logic [rba_pkg::CNT_W-1:0]       best_cnt_q;

	logic                            out_valid_q;
	logic [rba_pkg::ROOM_W-1:0]      room_q;
	logic [rba_pkg::OUT_TIME_W-1:0]  booked_until_q;
	logic [rba_pkg::ROOM_W-1:0]      most_booked_q;
	logic                            batch_done_q;

	logic                            accept;
	logic                            proceed;
	logic [IW-1:0]                   scan_room;
	logic [IW-1:0]                   pick_w;
	logic [IW-1:0]                   rd_addr;
	logic [TIME_BITS-1:0]            rd_free;
	logic [rba_pkg::CNT_W-1:0]       rd_cnt;
	logic [rba_pkg::CNT_W-1:0]       new_cnt;
	logic                            free_hit;
	logic                            earlier;
	logic [TIME_BITS-1:0]            booked_w;
	logic [IW-1:0]                   best_room_w;
	logic [rba_pkg::CNT_W-1:0]       best_cnt_w;
	rba_pkg::store_ctl_t             ctl;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign proceed  = !out_valid_q || !out_stall;

	always_comb begin
		if (room_count_q == '0) begin
			n_w = CW'(1);
		end else if (int'(room_count_q) > MAX_ROOMS) begin
			n_w = CW'(MAX_ROOMS);
		end else begin
			n_w = CW'(room_count_q);
		end
	end

	// The read data in a scan cycle belongs to the room issued in the cycle before.
	assign scan_room = IW'(idx_q - CW'(1));
	assign pick_w    = found_q ? pick_q : early_q;

	always_comb begin
		unique case (state_q)
			ST_SCAN:   rd_addr = (idx_q < n_q) ? IW'(idx_q) : '0;
			ST_FETCH:  rd_addr = pick_w;
			ST_UPDATE: rd_addr = pick_q;
			default:   rd_addr = '0;
		endcase
	end

	assign new_cnt = (rd_cnt == rba_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

	// Only the picked room's count grows, so the leader moves to it when it
	// passes the old best or ties it from a lower index.
	always_comb begin
		best_room_w = best_room_q;
		best_cnt_w  = best_cnt_q;
		if (new_cnt > best_cnt_q || (new_cnt == best_cnt_q && pick_q < best_room_q)) begin
			best_room_w = pick_q;
			best_cnt_w  = new_cnt;
		end
	end

	assign ctl.wr_en = state_q == ST_UPDATE && proceed;
	assign ctl.clear = state_q == ST_UPDATE && proceed && last_q;

	rba_room_store #(
		.MAX_ROOMS(MAX_ROOMS),
		.TIME_BITS(TIME_BITS),
		.IW       (IW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wr_addr(pick_q),
		.wr_free(booked_q),
		.wr_cnt (new_cnt),
		.rd_addr(rd_addr),
		.rd_free(rd_free),
		.rd_cnt (rd_cnt)
	);

	rba_cmp_unit #(
		.TIME_BITS(TIME_BITS)
	) u_cmp (
		.room_free (rd_free),
		.early_free(early_free_q),
		.start     (start_q),
		.dur       (dur_q),
		.use_start (found_q),
		.free_hit  (free_hit),
		.earlier   (earlier),
		.booked    (booked_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= rba_pkg::ROOM_COUNT_RST;
		end else if (cfg_wr_en) begin
			room_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_room_q <= '0;
			best_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_UPDATE && proceed) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q != '0) begin
						if (!found_q && free_hit) begin
							found_q <= 1'b1;
						end
					end
					if (idx_q == n_q) begin
						state_q <= ST_FETCH;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_FETCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (proceed) begin
						if (last_q) begin
							best_room_q <= '0;
							best_cnt_q  <= '0;
						end else begin
							best_room_q <= best_room_w;
							best_cnt_q  <= best_cnt_w;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_time;
			dur_q   <= (stop_time >= start_time) ? stop_time - start_time : '0;
			last_q  <= last_meeting;
			n_q     <= n_w;
		end
		if (state_q == ST_SCAN && idx_q != '0) begin
			if (!found_q && free_hit) begin
				pick_q <= scan_room;
			end
			if (idx_q == CW'(1) || earlier) begin
				early_q      <= scan_room;
				early_free_q <= rd_free;
			end
		end
		if (state_q == ST_FETCH) begin
			pick_q   <= pick_w;
			booked_q <= booked_w;
		end
		if (state_q == ST_UPDATE && proceed) begin
			room_q         <= rba_pkg::ROOM_W'(pick_q);
			booked_until_q <= rba_pkg::OUT_TIME_W'(booked_q);
			most_booked_q  <= rba_pkg::ROOM_W'(best_room_w);
			batch_done_q   <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign room         = room_q;
	assign booked_until = booked_until_q;
	assign most_booked  = most_booked_q;
	assign batch_done   = batch_done_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while a request is still in work");

	a_load_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_UPDATE)
		else $error("result loaded outside the update step");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> int'(pick_q) < int'(n_q))
		else $error("picked room lies beyond the rooms in use");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= n_q)
		else $error("scan index ran past the room count");

endmodule
